>>> design/suse_pkg.sv
// ----------------------------------------------------------------------------
// suse_pkg : shared types and codes for the sorted unique set engine
// Request/result payloads, operation and status codes, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package suse_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic                      action;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] element;
    logic                      element_valid;
    logic                      last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the request and compare it against every cell
    logic update;   // apply the operation and load the listing row
    logic advance;  // a result was taken: shift the listing row
  } suse_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_result;
  } suse_sts_t;

endpackage

>>> design/sorted_unique_set_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_engine_core : sorted set of distinct signed values
// Each request inserts or deletes one signed 32-bit value in a set of at
// most DEPTH distinct entries kept in ascending order. A duplicate insert is
// ignored, an insert into a full set is rejected, and a delete of an absent
// value is reported. After every request the whole set is listed in
// ascending order as a run of results, all carrying the same status and
// count, with last set on the final one; an empty set lists as a single
// result with element_valid low. Each request is captured and compared
// against every stored cell at once, then the cell row shifts and the
// listing row loads, then the listing row shifts out one element per
// result, holding while the result side stalls. One request is in work
// at a time; req_ready is high only between runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_unique_set_engine_core #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  suse_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_ready,
  output suse_pkg::res_t res_data
);

  // Count must hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);

  suse_pkg::suse_cmd_t cmd;
  suse_pkg::suse_sts_t sts;

  // Sequence capture, update and listing; own both handshakes
  suse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the sorted cells, apply the operation, shift out the listing
  suse_dp #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .sts      (sts),
    .res_data (res_data)
  );

endmodule

>>> design/suse_ctrl.sv
// ----------------------------------------------------------------------------
// suse_ctrl : operation sequencer
// Steps each request through capture, update and listing, and drives the
// handshakes on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module suse_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                res_valid,
  input  logic                res_ready,
  input  suse_pkg::suse_sts_t sts,
  output suse_pkg::suse_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_LIST   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_LIST);

  assign cmd.capture = req_valid & req_ready;
  assign cmd.update  = (state == S_UPDATE);
  assign cmd.advance = res_valid & res_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        state_next = S_LIST;
      end
      S_LIST: begin
        if (res_ready && sts.last_result) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/suse_dp.sv
// ----------------------------------------------------------------------------
// suse_dp : set storage and listing datapath
// A row of sorted cells that compare against the request in parallel and
// shift by one place to insert or remove, plus a listing row that shifts
// the updated set out one element per result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module suse_dp #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  suse_pkg::req_t      req_data,
  input  suse_pkg::suse_cmd_t cmd,
  output suse_pkg::suse_sts_t sts,
  output suse_pkg::res_t      res_data
);

  localparam int VW = suse_pkg::VALUE_W;

  // Set storage, sorted ascending in cells below count
  logic signed [VW-1:0] ent      [DEPTH];
  logic signed [VW-1:0] ent_next [DEPTH];
  logic signed [VW-1:0] ins_val  [DEPTH];
  logic signed [VW-1:0] del_val  [DEPTH];
  logic signed [VW-1:0] lst      [DEPTH];

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] remain;

  // Captured request and per-cell compare flags
  logic                  act;
  logic signed [VW-1:0]  val;
  logic [DEPTH-1:0]      below;
  logic [DEPTH-1:0]      hit;

  logic [suse_pkg::STATUS_W-1:0] status;
  logic [suse_pkg::STATUS_W-1:0] status_next;

  logic found;
  logic full;
  logic do_ins;
  logic do_del;
  logic [31:0] count_wide;

  assign found = |hit;
  assign full  = (count == CNT_W'(DEPTH));

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    count_next  = count;
    status_next = suse_pkg::ST_NOT_FOUND;
    case (act)
      suse_pkg::ACT_INSERT: begin
        if (found) begin
          status_next = suse_pkg::ST_DUPLICATE;
        end else if (full) begin
          status_next = suse_pkg::ST_FULL;
        end else begin
          do_ins      = 1'b1;
          count_next  = count + CNT_W'(1);
          status_next = suse_pkg::ST_INSERTED;
        end
      end
      suse_pkg::ACT_DELETE: begin
        if (found) begin
          do_del      = 1'b1;
          count_next  = count - CNT_W'(1);
          status_next = suse_pkg::ST_REMOVED;
        end
      end
      default: begin
        status_next = suse_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // Insert: cells below the slot hold, the slot takes the value, the rest
    // take their lower neighbor.
    if (i == 0) begin : g_ins_first
      assign ins_val[i] = below[i] ? ent[i] : val;
    end else begin : g_ins_rest
      assign ins_val[i] = below[i]   ? ent[i]   :
                          below[i-1] ? val      : ent[i-1];
    end
    // Delete: cells at or above the slot take their upper neighbor.
    if (i == DEPTH - 1) begin : g_del_last
      assign del_val[i] = ent[i];
    end else begin : g_del_rest
      assign del_val[i] = below[i] ? ent[i] : ent[i+1];
    end

    assign ent_next[i] = do_ins ? ins_val[i] :
                         do_del ? del_val[i] : ent[i];

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        below[i] <= (CNT_W'(i) < count) && (ent[i] < req_data.value);
        hit[i]   <= (CNT_W'(i) < count) && (ent[i] == req_data.value);
      end
      if (cmd.update) begin
        ent[i] <= ent_next[i];
      end
    end

    if (i == DEPTH - 1) begin : g_lst_last
      always_ff @(posedge clk) begin
        if (cmd.update) lst[i] <= ent_next[i];
      end
    end else begin : g_lst_rest
      always_ff @(posedge clk) begin
        if (cmd.update) begin
          lst[i] <= ent_next[i];
        end else if (cmd.advance) begin
          lst[i] <= lst[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= req_data.action;
      val <= req_data.value;
    end
    if (cmd.update) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      remain <= '0;
    end else if (cmd.update) begin
      count  <= count_next;
      remain <= (count_next == '0) ? CNT_W'(1) : count_next;
    end else if (cmd.advance) begin
      remain <= remain - CNT_W'(1);
    end
  end

  assign sts.last_result = (remain == CNT_W'(1));

  assign count_wide             = 32'(count);
  assign res_data.status        = status;
  assign res_data.count         = count_wide[suse_pkg::COUNT_W-1:0];
  assign res_data.element_valid = (count != '0);
  assign res_data.element       = (count != '0) ? lst[0] : '0;
  assign res_data.last          = sts.last_result;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench : self-checking bench for sorted_unique_set_engine_core
// Drive insert and delete requests through the valid/ready request port.
// Predict each listing run from a private sorted copy of the set, and check
// every result field against the oldest pending expectation. Both ports
// idle at random. The result side holds off once for a long stretch so
// that the block backs up and stalls its request port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int SET_DEPTH   = 16;
  localparam int IDLE_PCT    = 23;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CALM_FROM   = 3000;    // no idling on either side in this window
  localparam int CALM_TO     = 4500;
  localparam int HOLD_AT     = 1500;    // result side holds off here
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;      // well over the longest listing run

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  suse_pkg::req_t req_data  = '0;
  logic           res_valid;
  logic           res_ready = 1'b0;
  suse_pkg::res_t res_data;

  // Stimulus and scoreboard state
  suse_pkg::req_t                      pending_reqs[$];   // requests not yet offered
  logic signed [suse_pkg::VALUE_W-1:0] stim_members[$];   // membership seen by the generator
  suse_pkg::res_t                      listing_due[$];    // expected results, oldest first
  logic signed [suse_pkg::VALUE_W-1:0] set_vals[SET_DEPTH];
  int                                  set_size     = 0;
  int                                  total_reqs   = 0;
  int                                  reqs_taken   = 0;
  int                                  error_count  = 0;
  int                                  cycle        = 0;
  int                                  hold_left    = 0;
  logic                                req_taken    = 1'b0;

  sorted_unique_set_engine_core #(
    .DEPTH(SET_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  always #4 clk = ~clk;

  // Count cycles and end the run if it hangs.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle);
      $display("** sorted_unique_set_engine_core: FAILED **");
      $finish;
    end
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  // Apply one request to the private set and queue the listing it causes.
  function automatic void predict_listing(input suse_pkg::req_t r);
    int                            slot;
    bit                            hit;
    logic [suse_pkg::STATUS_W-1:0] st;
    suse_pkg::res_t                item;
    slot = 0;
    while (slot < set_size && set_vals[slot] < r.value)
      slot++;
    hit = (slot < set_size) && (set_vals[slot] == r.value);

    if (r.action == suse_pkg::ACT_INSERT) begin
      if (hit) begin
        st = suse_pkg::ST_DUPLICATE;
      end else if (set_size >= SET_DEPTH) begin
        st = suse_pkg::ST_FULL;
      end else begin
        // open a gap at the insertion point
        for (int k = set_size; k > slot; k--)
          set_vals[k] = set_vals[k-1];
        set_vals[slot] = r.value;
        set_size++;
        st = suse_pkg::ST_INSERTED;
      end
    end else if (hit) begin
      // close the gap left by the removed value
      for (int k = slot; k < set_size - 1; k++)
        set_vals[k] = set_vals[k+1];
      set_size--;
      st = suse_pkg::ST_REMOVED;
    end else begin
      st = suse_pkg::ST_NOT_FOUND;
    end

    item.status = st;
    item.count  = suse_pkg::COUNT_W'(set_size);
    if (set_size == 0) begin
      // an empty set lists as one result without an element
      item.element       = '0;
      item.element_valid = 1'b0;
      item.last          = 1'b1;
      listing_due.push_back(item);
    end else begin
      for (int k = 0; k < set_size; k++) begin
        item.element       = set_vals[k];
        item.element_valid = 1'b1;
        item.last          = (k == set_size - 1);
        listing_due.push_back(item);
      end
    end
  endfunction

  task automatic check_result(input suse_pkg::res_t got);
    suse_pkg::res_t want;
    if (listing_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %p", got));
      return;
    end
    want = listing_due.pop_front();
    compare_field("status",        32'(got.status),        32'(want.status));
    compare_field("count",         32'(got.count),         32'(want.count));
    compare_field("element",       got.element,            want.element);
    compare_field("element_valid", 32'(got.element_valid), 32'(want.element_valid));
    compare_field("last",          32'(got.last),          32'(want.last));
  endtask

  // Monitor: sample both handshakes at the rising edge. Check a result before
  // predicting from a request taken at the same edge.
  always @(posedge clk) begin
    req_taken <= !rst && req_valid && req_ready;
    if (!rst) begin
      if (res_valid && res_ready)
        check_result(res_data);
      if (req_valid && req_ready) begin
        predict_listing(req_data);
        reqs_taken <= reqs_taken + 1;
      end
    end
  end

  function automatic bit in_calm_window();
    return cycle >= CALM_FROM && cycle < CALM_TO;
  endfunction

  // Driver: hold a request until it is taken, then offer the next one or idle.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // hold valid and payload until the handshake completes
    end else if (pending_reqs.size() != 0 &&
                 (in_calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
      req_data  <= pending_reqs.pop_front();
      req_valid <= 1'b1;
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Result side: random stalls, plus one long hold-off that backs the block up.
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (cycle == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= in_calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Queue one request and track membership so that later choices hit it.
  function automatic void queue_req(input logic act,
                                    input logic signed [suse_pkg::VALUE_W-1:0] v);
    suse_pkg::req_t r;
    int             at;
    r.action = act;
    r.value  = v;
    pending_reqs.push_back(r);
    at = -1;
    foreach (stim_members[i])
      if (stim_members[i] == v) at = i;
    if (act == suse_pkg::ACT_INSERT && at < 0 && stim_members.size() < SET_DEPTH)
      stim_members.push_back(v);
    else if (act == suse_pkg::ACT_DELETE && at >= 0)
      stim_members.delete(at);
  endfunction

  // Mix full-range values with clusters near zero and near both extremes,
  // so that ordering, duplicates and sign boundaries all get exercised.
  function automatic logic signed [suse_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return int'($urandom_range(0, 64)) - 32;
      2:       return 32'sh8000_0000 + int'($urandom_range(0, 15));
      default: return 32'sh7fff_ffff - int'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin : stimulus
    logic signed [suse_pkg::VALUE_W-1:0] fill_vals[12];
    logic signed [suse_pkg::VALUE_W-1:0] v;
    int                                  ins_pct;

    // Directed: empty set, extremes, duplicate, absent delete, then fill up.
    queue_req(suse_pkg::ACT_DELETE, 32'sd5);              // delete from empty set
    queue_req(suse_pkg::ACT_INSERT, 32'sd0);
    queue_req(suse_pkg::ACT_INSERT, 32'sh8000_0000);      // most negative
    queue_req(suse_pkg::ACT_INSERT, 32'sh7fff_ffff);      // most positive
    queue_req(suse_pkg::ACT_INSERT, 32'sh7fff_ffff);      // duplicate
    queue_req(suse_pkg::ACT_INSERT, -32'sd1);
    fill_vals = '{32'sd1, 32'sd2, -32'sd2, 32'sd100, -32'sd100, 32'sh4000_0000,
                  32'shc000_0000, 32'sh0000_ffff, 32'shffff_0000, 32'sh7fff_fffe,
                  32'sh8000_0001, 32'sh5555_5555};
    foreach (fill_vals[i])
      queue_req(suse_pkg::ACT_INSERT, fill_vals[i]);
    queue_req(suse_pkg::ACT_INSERT, 32'shaaaa_aaaa);      // full set: rejected
    queue_req(suse_pkg::ACT_INSERT, 32'sd100);            // full set, value present: duplicate
    queue_req(suse_pkg::ACT_DELETE, 32'sh8000_0000);      // delete lowest entry
    queue_req(suse_pkg::ACT_DELETE, 32'sd7);              // absent delete

    // Random: alternate fill-heavy, balanced and drain-heavy stretches.
    for (int seg = 0; seg < 12; seg++) begin
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        default: ins_pct = 15;
      endcase
      for (int n = 0; n < 34; n++) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          if (stim_members.size() != 0 && $urandom_range(0, 99) < 15)
            v = stim_members[$urandom_range(0, stim_members.size() - 1)];
          else
            v = pick_value();
          queue_req(suse_pkg::ACT_INSERT, v);
        end else begin
          if (stim_members.size() != 0 && $urandom_range(0, 99) < 80)
            v = stim_members[$urandom_range(0, stim_members.size() - 1)];
          else
            v = pick_value();
          queue_req(suse_pkg::ACT_DELETE, v);
        end
      end
    end
    total_reqs = pending_reqs.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every request taken and every expected result seen.
    while (reqs_taken < total_reqs || listing_due.size() != 0)
      @(negedge clk);
    // Catch any stray result after the last expected one.
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0)
      $display("** sorted_unique_set_engine_core: PASSED **");
    else
      $display("** sorted_unique_set_engine_core: FAILED **");
    $finish;
  end

endmodule
